/* rtl/cir_pkg.sv */
// cir_pkg: shared types, lane map and constants for the contact impulse resolver.
// Used by cir_front, cir_div, cir_post and contact_impulse_resolve. No dependencies.
package cir_pkg;

   localparam int LANES = 12;   // 6 position quotients, 6 velocity quotients
   localparam int NW    = 64;   // dividend width
   localparam int DW    = 42;   // divisor width
   localparam int QW    = 28;   // quotient bits, one per divider stage
   localparam int CW    = 21;   // packed vector component width

   localparam int LANE_PA = 0;
   localparam int LANE_PB = 3;
   localparam int LANE_VA = 6;
   localparam int LANE_VB = 9;

   typedef logic [NW-1:0] num_type;
   typedef logic [DW-1:0] den_type;
   typedef logic [QW-1:0] quo_type;

   typedef enum logic [1:0] {
      STAT_SKIP    = 2'd0,
      STAT_SEP     = 2'd1,
      STAT_IMPULSE = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]  neg;     // normal component sign
      logic        skip;    // summed inverse mass is zero
      logic        sep;     // bodies separating
      logic [62:0] vel_a;
      logic [62:0] vel_b;
   } side_type;

   function automatic logic [CW-1:0] sat21(input logic signed [29:0] v);
      logic [CW-1:0] r;
      if (v > 30'sd1048575) begin
         r = 21'h0FFFFF;
      end else if (v < -30'sd1048576) begin
         r = 21'h100000;
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/cir_front.sv */
// cir_front: eight-stage front end; builds dividends and divisors for all lanes.
// Depends on cir_pkg.
module cir_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [15:0]                     normal_x,
   input  logic signed [15:0]                     normal_y,
   input  logic signed [15:0]                     normal_z,
   input  logic [19:0]                            depth,
   input  logic [23:0]                            inv_mass_a,
   input  logic [23:0]                            inv_mass_b,
   input  logic [62:0]                            vel_a,
   input  logic [62:0]                            vel_b,
   input  logic [16:0]                            restit_a,
   input  logic [16:0]                            restit_b,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output cir_pkg::num_type [cir_pkg::LANES-1:0]  out_num,
   output cir_pkg::den_type [cir_pkg::LANES-1:0]  out_den,
   output cir_pkg::side_type                      out_side
);

   localparam int NSTG = 8;
   localparam logic [19:0] SLOP = 20'd20;   // 0.005 in Q8.12

   logic v_ff [NSTG];
   logic adv  [NSTG];

   assign adv[NSTG-1] = !v_ff[NSTG-1] || out_ready;
   for (genvar k = 0; k < NSTG-1; k++) begin : g_adv
      assign adv[k] = !v_ff[k] || adv[k+1];
   end
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTG; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (adv[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   logic signed [15:0] nrm [3];
   assign nrm[0] = normal_x;
   assign nrm[1] = normal_y;
   assign nrm[2] = normal_z;

   // stage 1: unpack
   logic signed [15:0] n1_ff [3];
   logic [15:0]        an1_ff [3];
   logic signed [21:0] dif1_ff [3];
   logic [24:0]        sum1_ff;
   logic [19:0]        exc1_ff;
   logic [16:0]        e1_ff;
   logic [23:0]        ima1_ff, imb1_ff;
   cir_pkg::side_type  side1_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int i = 0; i < 3; i++) begin
            n1_ff[i]   <= nrm[i];
            an1_ff[i]  <= nrm[i][15] ? 16'(-nrm[i]) : 16'(nrm[i]);
            dif1_ff[i] <= 22'($signed(vel_a[21*i +: 21])) - 22'($signed(vel_b[21*i +: 21]));
            side1_ff.neg[i] <= nrm[i][15];
         end
         sum1_ff <= {1'b0, inv_mass_a} + {1'b0, inv_mass_b};
         exc1_ff <= (depth > SLOP) ? depth - SLOP : '0;
         e1_ff   <= (restit_a < restit_b) ? restit_a : restit_b;
         ima1_ff <= inv_mass_a;
         imb1_ff <= inv_mass_b;
         side1_ff.skip  <= 1'b0;
         side1_ff.sep   <= 1'b0;
         side1_ff.vel_a <= vel_a;
         side1_ff.vel_b <= vel_b;
      end
   end

   // stage 2: first products
   logic [35:0]        t2_ff [3];
   logic signed [37:0] pr2_ff [3];
   logic [39:0]        ab2_ff [6];
   logic [27:0]        d5_2_ff;
   logic [24:0]        sum2_ff;
   logic [17:0]        g2_ff;
   logic [23:0]        ima2_ff, imb2_ff;
   cir_pkg::side_type  side2_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int i = 0; i < 3; i++) begin
            t2_ff[i]    <= {20'b0, an1_ff[i]} * {16'b0, exc1_ff};
            pr2_ff[i]   <= 38'(dif1_ff[i]) * 38'(n1_ff[i]);
            ab2_ff[i]   <= {24'b0, an1_ff[i]} * {16'b0, ima1_ff};
            ab2_ff[i+3] <= {24'b0, an1_ff[i]} * {16'b0, imb1_ff};
         end
         d5_2_ff <= {3'b0, sum1_ff} + {1'b0, sum1_ff, 2'b0};
         sum2_ff <= sum1_ff;
         g2_ff   <= {1'b0, e1_ff} + 18'h10000;
         ima2_ff <= ima1_ff;
         imb2_ff <= imb1_ff;
         side2_ff.neg   <= side1_ff.neg;
         side2_ff.skip  <= (sum1_ff == '0);
         side2_ff.sep   <= side1_ff.sep;
         side2_ff.vel_a <= side1_ff.vel_a;
         side2_ff.vel_b <= side1_ff.vel_b;
      end
   end

   // stage 3: relative normal velocity, position partial products
   logic signed [39:0] rel3_ff;
   logic [41:0]        pl3_ff [6];
   logic [41:0]        ph3_ff [6];
   logic [39:0]        ab3_ff [6];
   logic [27:0]        d5_3_ff;
   logic [24:0]        sum3_ff;
   logic [17:0]        g3_ff;
   cir_pkg::side_type  side3_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         rel3_ff <= 40'(pr2_ff[0]) + 40'(pr2_ff[1]) + 40'(pr2_ff[2]);
         for (int i = 0; i < 3; i++) begin
            pl3_ff[i]   <= {24'b0, t2_ff[i][17:0]} * {18'b0, ima2_ff};
            ph3_ff[i]   <= {24'b0, t2_ff[i][35:18]} * {18'b0, ima2_ff};
            pl3_ff[i+3] <= {24'b0, t2_ff[i][17:0]} * {18'b0, imb2_ff};
            ph3_ff[i+3] <= {24'b0, t2_ff[i][35:18]} * {18'b0, imb2_ff};
         end
         ab3_ff   <= ab2_ff;
         d5_3_ff  <= d5_2_ff;
         sum3_ff  <= sum2_ff;
         g3_ff    <= g2_ff;
         side3_ff <= side2_ff;
      end
   end

   // stage 4: closing speed magnitude, position dividends
   logic signed [39:0] nrel;
   logic [59:0]        psum [6];
   assign nrel = -rel3_ff;
   always_comb begin
      for (int j = 0; j < 6; j++) begin
         psum[j] = {ph3_ff[j], 18'b0} + {18'b0, pl3_ff[j]};
      end
   end

   logic [37:0]        mag4_ff;
   logic [61:0]        np4_ff [6];
   logic [39:0]        ab4_ff [6];
   logic [27:0]        d5_4_ff;
   logic [24:0]        sum4_ff;
   logic [17:0]        g4_ff;
   cir_pkg::side_type  side4_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         mag4_ff <= nrel[37:0];
         for (int j = 0; j < 6; j++) begin
            np4_ff[j] <= {psum[j], 2'b0};
         end
         ab4_ff         <= ab3_ff;
         d5_4_ff        <= d5_3_ff;
         sum4_ff        <= sum3_ff;
         g4_ff          <= g3_ff;
         side4_ff.neg   <= side3_ff.neg;
         side4_ff.skip  <= side3_ff.skip;
         side4_ff.sep   <= (rel3_ff > 40'sd0);
         side4_ff.vel_a <= side3_ff.vel_a;
         side4_ff.vel_b <= side3_ff.vel_b;
      end
   end

   // stage 5: (1 + e) times closing speed, two halves
   logic [36:0]        nl5_ff, nh5_ff;
   logic [61:0]        np5_ff [6];
   logic [39:0]        ab5_ff [6];
   logic [27:0]        d5_5_ff;
   logic [24:0]        sum5_ff;
   cir_pkg::side_type  side5_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         nl5_ff   <= {19'b0, g4_ff} * {18'b0, mag4_ff[18:0]};
         nh5_ff   <= {19'b0, g4_ff} * {18'b0, mag4_ff[37:19]};
         np5_ff   <= np4_ff;
         ab5_ff   <= ab4_ff;
         d5_5_ff  <= d5_4_ff;
         sum5_ff  <= sum4_ff;
         side5_ff <= side4_ff;
      end
   end

   // stage 6: combine halves
   logic [55:0]        num6_ff;
   logic [61:0]        np6_ff [6];
   logic [39:0]        ab6_ff [6];
   logic [27:0]        d5_6_ff;
   logic [24:0]        sum6_ff;
   cir_pkg::side_type  side6_ff;

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         num6_ff  <= {nh5_ff, 19'b0} + {19'b0, nl5_ff};
         np6_ff   <= np5_ff;
         ab6_ff   <= ab5_ff;
         d5_6_ff  <= d5_5_ff;
         sum6_ff  <= sum5_ff;
         side6_ff <= side5_ff;
      end
   end

   // stage 7: impulse partial products, 20 x 28 each
   logic [47:0]        p00_ff [6];
   logic [47:0]        p01_ff [6];
   logic [47:0]        p10_ff [6];
   logic [47:0]        p11_ff [6];
   logic [61:0]        np7_ff [6];
   logic [27:0]        d5_7_ff;
   logic [24:0]        sum7_ff;
   cir_pkg::side_type  side7_ff;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         for (int j = 0; j < 6; j++) begin
            p00_ff[j] <= {28'b0, ab6_ff[j][19:0]} * {20'b0, num6_ff[27:0]};
            p01_ff[j] <= {28'b0, ab6_ff[j][19:0]} * {20'b0, num6_ff[55:28]};
            p10_ff[j] <= {28'b0, ab6_ff[j][39:20]} * {20'b0, num6_ff[27:0]};
            p11_ff[j] <= {28'b0, ab6_ff[j][39:20]} * {20'b0, num6_ff[55:28]};
         end
         np7_ff   <= np6_ff;
         d5_7_ff  <= d5_6_ff;
         sum7_ff  <= sum6_ff;
         side7_ff <= side6_ff;
      end
   end

   // stage 8: sum partials, drop 44 fraction bits, build lanes
   logic [95:0] full [6];
   always_comb begin
      for (int j = 0; j < 6; j++) begin
         full[j] = {48'b0, p00_ff[j]} + {20'b0, p01_ff[j], 28'b0}
                 + {28'b0, p10_ff[j], 20'b0} + {p11_ff[j], 48'b0};
      end
   end

   cir_pkg::num_type [cir_pkg::LANES-1:0] num8_ff;
   cir_pkg::den_type [cir_pkg::LANES-1:0] den8_ff;
   cir_pkg::side_type                     side8_ff;

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         for (int j = 0; j < 6; j++) begin
            num8_ff[cir_pkg::LANE_PA+j] <= {2'b0, np7_ff[j]};
            den8_ff[cir_pkg::LANE_PA+j] <= {d5_7_ff, 14'b0};
            num8_ff[cir_pkg::LANE_VA+j] <= {12'b0, full[j][95:44]};
            den8_ff[cir_pkg::LANE_VA+j] <= {17'b0, sum7_ff};
         end
         side8_ff <= side7_ff;
      end
   end

   assign out_valid = v_ff[NSTG-1];
   assign out_num   = num8_ff;
   assign out_den   = den8_ff;
   assign out_side  = side8_ff;

endmodule

/* rtl/cir_div.sv */
// cir_div: pipelined restoring divider, one quotient bit per stage, all lanes in parallel.
// Depends on cir_pkg.
module cir_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  cir_pkg::num_type [cir_pkg::LANES-1:0]  in_num,
   input  cir_pkg::den_type [cir_pkg::LANES-1:0]  in_den,
   input  cir_pkg::side_type                      in_side,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output cir_pkg::quo_type [cir_pkg::LANES-1:0]  out_quo,
   output cir_pkg::side_type                      out_side
);

   localparam int QW    = cir_pkg::QW;
   localparam int DW    = cir_pkg::DW;
   localparam int NW    = cir_pkg::NW;
   localparam int LANES = cir_pkg::LANES;

   logic              v_ff    [QW];
   logic              adv     [QW];
   logic [DW-1:0]     rem_ff  [QW][LANES];
   logic [QW-1:0]     low_ff  [QW][LANES];
   logic [DW-1:0]     den_ff  [QW][LANES];
   cir_pkg::side_type side_ff [QW];

   assign adv[QW-1] = !v_ff[QW-1] || out_ready;
   for (genvar k = 0; k < QW-1; k++) begin : g_adv
      assign adv[k] = !v_ff[k] || adv[k+1];
   end
   assign in_ready = adv[0];

   for (genvar k = 0; k < QW; k++) begin : g_stg
      logic [DW-1:0]     rem_s [LANES];
      logic [QW-1:0]     low_s [LANES];
      logic [DW-1:0]     den_s [LANES];
      logic [DW:0]       cand  [LANES];
      logic              ge    [LANES];
      cir_pkg::side_type side_s;
      logic              vld_s;

      if (k == 0) begin : g_first
         // dividend is known to be below divisor * 2^QW
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               rem_s[l] = DW'(in_num[l][NW-1:QW]);
               low_s[l] = in_num[l][QW-1:0];
               den_s[l] = in_den[l];
            end
            side_s = in_side;
            vld_s  = in_valid;
         end
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               rem_s[l] = rem_ff[k-1][l];
               low_s[l] = low_ff[k-1][l];
               den_s[l] = den_ff[k-1][l];
            end
            side_s = side_ff[k-1];
            vld_s  = v_ff[k-1];
         end
      end

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            cand[l] = {rem_s[l], low_s[l][QW-1]};
            ge[l]   = (cand[l] >= {1'b0, den_s[l]});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            v_ff[k] <= vld_s;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            for (int l = 0; l < LANES; l++) begin
               rem_ff[k][l] <= ge[l] ? DW'(cand[l] - {1'b0, den_s[l]}) : cand[l][DW-1:0];
               low_ff[k][l] <= {low_s[l][QW-2:0], ge[l]};
               den_ff[k][l] <= den_s[l];
            end
            side_ff[k] <= side_s;
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = low_ff[QW-1][l];
      end
   end
   assign out_valid = v_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

/* rtl/cir_post.sv */
// cir_post: applies signs, adds velocity deltas, saturates, packs; holds the output word.
// Depends on cir_pkg.
module cir_post (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  cir_pkg::quo_type [cir_pkg::LANES-1:0]  in_quo,
   input  cir_pkg::side_type                      in_side,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [62:0]                            pos_corr_a,
   output logic [62:0]                            pos_corr_b,
   output logic [62:0]                            new_vel_a,
   output logic [62:0]                            new_vel_b,
   output logic [1:0]                             status
);

   localparam int CW = cir_pkg::CW;

   logic signed [29:0] qpa, qpb, qva, qvb, va, vb;
   logic [62:0]        pca, pcb, nva, nvb;
   cir_pkg::status_type st;

   always_comb begin
      pca = '0;
      pcb = '0;
      nva = in_side.vel_a;
      nvb = in_side.vel_b;
      for (int i = 0; i < 3; i++) begin
         qpa = $signed({2'b0, in_quo[cir_pkg::LANE_PA+i]});
         qpb = $signed({2'b0, in_quo[cir_pkg::LANE_PB+i]});
         qva = $signed({2'b0, in_quo[cir_pkg::LANE_VA+i]});
         qvb = $signed({2'b0, in_quo[cir_pkg::LANE_VB+i]});
         if (in_side.neg[i]) begin
            qpa = -qpa;
            qpb = -qpb;
            qva = -qva;
            qvb = -qvb;
         end
         va = 30'($signed(in_side.vel_a[CW*i +: CW]));
         vb = 30'($signed(in_side.vel_b[CW*i +: CW]));
         if (!in_side.skip) begin
            pca[CW*i +: CW] = cir_pkg::sat21(qpa);
            pcb[CW*i +: CW] = cir_pkg::sat21(qpb);
            if (!in_side.sep) begin
               nva[CW*i +: CW] = cir_pkg::sat21(va + qva);
               nvb[CW*i +: CW] = cir_pkg::sat21(vb - qvb);
            end
         end
      end
      if (in_side.skip) begin
         st = cir_pkg::STAT_SKIP;
      end else if (in_side.sep) begin
         st = cir_pkg::STAT_SEP;
      end else begin
         st = cir_pkg::STAT_IMPULSE;
      end
   end

   logic        vld_ff;
   logic [62:0] pca_ff, pcb_ff, nva_ff, nvb_ff;
   logic [1:0]  st_ff;

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         pca_ff <= pca;
         pcb_ff <= pcb;
         nva_ff <= nva;
         nvb_ff <= nvb;
         st_ff  <= st;
      end
   end

   assign out_valid  = vld_ff;
   assign pos_corr_a = pca_ff;
   assign pos_corr_b = pcb_ff;
   assign new_vel_a  = nva_ff;
   assign new_vel_b  = nvb_ff;
   assign status     = st_ff;

endmodule

/* rtl/contact_impulse_resolve.sv */
// contact_impulse_resolve: top level, front end -> divider -> output stage.
// Depends on cir_pkg, cir_front, cir_div, cir_post.
//
//  channel | ports                      | direction | word
//  --------+----------------------------+-----------+------------------------------
//  req     | req_valid/req_ready + data | in        | normal, depth, masses, vel, e
//  rsp     | rsp_valid/rsp_ready + data | out       | corrections, velocities, status
//
// One contact per cycle sustained while rsp_ready stays high; front end, divider and output stage run in that order.
// The 28-stage divider, one quotient bit per stage, sets the latency.
// reset is synchronous and clears only the valid bits.
// Each stage moves when its successor is empty or moving, so bubbles close up
// under an output stall and no word is lost or repeated.
module contact_impulse_resolve (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   input  logic [19:0]        req_depth,
   input  logic [23:0]        req_inv_mass_a,
   input  logic [23:0]        req_inv_mass_b,
   input  logic [62:0]        req_vel_a,
   input  logic [62:0]        req_vel_b,
   input  logic [16:0]        req_restit_a,
   input  logic [16:0]        req_restit_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [62:0]        rsp_pos_corr_a,
   output logic [62:0]        rsp_pos_corr_b,
   output logic [62:0]        rsp_new_vel_a,
   output logic [62:0]        rsp_new_vel_b,
   output logic [1:0]         rsp_status
);

   logic                                  fr_valid, fr_ready;
   cir_pkg::num_type [cir_pkg::LANES-1:0] fr_num;
   cir_pkg::den_type [cir_pkg::LANES-1:0] fr_den;
   cir_pkg::side_type                     fr_side;

   logic                                  dv_valid, dv_ready;
   cir_pkg::quo_type [cir_pkg::LANES-1:0] dv_quo;
   cir_pkg::side_type                     dv_side;

   cir_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .normal_x   (req_normal_x),
      .normal_y   (req_normal_y),
      .normal_z   (req_normal_z),
      .depth      (req_depth),
      .inv_mass_a (req_inv_mass_a),
      .inv_mass_b (req_inv_mass_b),
      .vel_a      (req_vel_a),
      .vel_b      (req_vel_b),
      .restit_a   (req_restit_a),
      .restit_b   (req_restit_b),
      .out_valid  (fr_valid),
      .out_ready  (fr_ready),
      .out_num    (fr_num),
      .out_den    (fr_den),
      .out_side   (fr_side)
   );

   cir_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_num    (fr_num),
      .in_den    (fr_den),
      .in_side   (fr_side),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   cir_post u_post (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dv_valid),
      .in_ready   (dv_ready),
      .in_quo     (dv_quo),
      .in_side    (dv_side),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .pos_corr_a (rsp_pos_corr_a),
      .pos_corr_b (rsp_pos_corr_b),
      .new_vel_a  (rsp_new_vel_a),
      .new_vel_b  (rsp_new_vel_b),
      .status     (rsp_status)
   );

endmodule
